FILE: rtl/core/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants for the axis-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

    localparam int FRAC_BITS_DEF   = 14;
    localparam int TRIG_STAGES_DEF = 16;

    // cordic datapath width, Q30 with headroom
    localparam int CORDIC_W = 34;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30         = 34'sd1073741824;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // angle units: 1/128 degree
    localparam logic signed [17:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;

    // pi in Q30 = PI_QUOT * HALF_TURN + PI_REM
    localparam logic [17:0] PI_QUOT   = 18'd146408;
    localparam logic [14:0] PI_REM    = 15'd19106;
    localparam logic [13:0] ROUND_ADD = 14'd11520;
    // floor(v / 45) = (v * DIV45_MUL) >> DIV45_SH for v below 2^19
    localparam logic [19:0] DIV45_MUL = 20'd745655;
    localparam int          DIV45_SH  = 25;

    // neg flag and three axis components ride along the cordic
    localparam int CARRY_W = 49;

endpackage

FILE: rtl/core/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic
// Unrolled rotation-mode cordic, one register stage per iteration.
// ----------------------------------------------------------------------------
module aarm_cordic
    import aarm_pkg::*;
#(
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] theta,
    input  logic [CARRY_W-1:0]         carry_in,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] cos_q30,
    output logic signed [CORDIC_W-1:0] sin_q30,
    output logic [CARRY_W-1:0]         carry_out
);

    logic                       valid_reg [TRIG_STAGES];
    logic signed [CORDIC_W-1:0] x_reg     [TRIG_STAGES];
    logic signed [CORDIC_W-1:0] y_reg     [TRIG_STAGES];
    logic signed [CORDIC_W-1:0] z_reg     [TRIG_STAGES];
    logic [CARRY_W-1:0]         carry_reg [TRIG_STAGES];

    genvar i;
    generate
        for (i = 0; i < TRIG_STAGES; i++)
        begin : g_stage
            localparam int K = i % 32;
            logic                       v_in;
            logic signed [CORDIC_W-1:0] x_in;
            logic signed [CORDIC_W-1:0] y_in;
            logic signed [CORDIC_W-1:0] z_in;
            logic [CARRY_W-1:0]         c_in;
            logic signed [CORDIC_W-1:0] x_next;
            logic signed [CORDIC_W-1:0] y_next;
            logic signed [CORDIC_W-1:0] z_next;
            logic signed [CORDIC_W-1:0] atan_k;

            if (i == 0)
            begin : g_first
                assign v_in = in_valid;
                assign x_in = CORDIC_GAIN_Q30;
                assign y_in = '0;
                assign z_in = theta;
                assign c_in = carry_in;
            end
            else
            begin : g_rest
                assign v_in = valid_reg[i-1];
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign c_in = carry_reg[i-1];
            end

            assign atan_k = $signed({{(CORDIC_W-32){1'b0}}, ATAN_Q30[K]});

            always_comb
            begin
                if (!z_in[CORDIC_W-1])
                begin
                    x_next = x_in - (y_in >>> K);
                    y_next = y_in + (x_in >>> K);
                    z_next = z_in - atan_k;
                end
                else
                begin
                    x_next = x_in + (y_in >>> K);
                    y_next = y_in - (x_in >>> K);
                    z_next = z_in + atan_k;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i]     <= x_next;
                    y_reg[i]     <= y_next;
                    z_reg[i]     <= z_next;
                    carry_reg[i] <= c_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[TRIG_STAGES-1];
    assign cos_q30   = x_reg[TRIG_STAGES-1];
    assign sin_q30   = y_reg[TRIG_STAGES-1];
    assign carry_out = carry_reg[TRIG_STAGES-1];

endmodule

FILE: rtl/core/axis_angle_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top
// Rodrigues rotation matrix from angle and axis, fixed point, saturated.
// ----------------------------------------------------------------------------
// throughput: one request per cycle; the whole pipeline holds while a result
//   waits on out_ready
// reset: rst_n clears every valid bit, payload registers are not reset
module axis_angle_rotation_matrix_top
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [16:0] angle_deg,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] r00,
    output logic signed [15:0] r01,
    output logic signed [15:0] r02,
    output logic signed [15:0] r10,
    output logic signed [15:0] r11,
    output logic signed [15:0] r12,
    output logic signed [15:0] r20,
    output logic signed [15:0] r21,
    output logic signed [15:0] r22
);

    localparam int PQ_W  = 32;
    localparam int SU_W  = CORDIC_W + 16;
    localparam int TPQ_W = CORDIC_W + PQ_W;
    localparam int ACC_W = TPQ_W + 2;

    logic en;
    logic out_valid_reg;

    assign en        = ~out_valid_reg | out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;

    // ---------------- stage a: reduce angle to [-90, 90] degrees
    logic signed [17:0] ang_wrap;
    logic signed [17:0] ang_fold;
    logic               fold_neg;
    logic signed [17:0] ang_abs;

    always_comb
    begin
        ang_wrap = 18'(angle_deg);
        if (ang_wrap >= HALF_TURN)
        begin
            ang_wrap = ang_wrap - FULL_TURN;
        end
        else if (ang_wrap < -HALF_TURN)
        begin
            ang_wrap = ang_wrap + FULL_TURN;
        end
        fold_neg = 1'b0;
        ang_fold = ang_wrap;
        if (ang_wrap > QUARTER_TURN)
        begin
            ang_fold = ang_wrap - HALF_TURN;
            fold_neg = 1'b1;
        end
        else if (ang_wrap < -QUARTER_TURN)
        begin
            ang_fold = ang_wrap + HALF_TURN;
            fold_neg = 1'b1;
        end
        ang_abs = ang_fold[17] ? -ang_fold : ang_fold;
    end

    logic               va_reg;
    logic [13:0]        mag_a_reg;
    logic               sgn_a_reg;
    logic [CARRY_W-1:0] car_a_reg;

    // ---------------- stage b1: magnitude times quotient and remainder of pi/HALF_TURN
    logic               vb1_reg;
    logic [31:0]        mq_b1_reg;
    logic [27:0]        mr_b1_reg;
    logic               sgn_b1_reg;
    logic [CARRY_W-1:0] car_b1_reg;

    // ---------------- stage b2: remainder part divided by HALF_TURN
    logic               vb2_reg;
    logic [31:0]        mq_b2_reg;
    logic [38:0]        dq_b2_reg;
    logic               sgn_b2_reg;
    logic [CARRY_W-1:0] car_b2_reg;

    // ---------------- stage b3: theta in Q30
    logic                       vb3_reg;
    logic signed [CORDIC_W-1:0] theta_b3_reg;
    logic [CARRY_W-1:0]         car_b3_reg;

    logic [CORDIC_W-1:0] theta_mag;
    assign theta_mag = CORDIC_W'(mq_b2_reg) + CORDIC_W'(dq_b2_reg[38:DIV45_SH]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
            vb3_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg  <= in_valid;
            vb1_reg <= va_reg;
            vb2_reg <= vb1_reg;
            vb3_reg <= vb2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg  <= ang_abs[13:0];
            sgn_a_reg  <= ang_fold[17];
            car_a_reg  <= {fold_neg, axis_x, axis_y, axis_z};

            mq_b1_reg  <= 32'(mag_a_reg) * 32'(PI_QUOT);
            mr_b1_reg  <= 28'(mag_a_reg) * 28'(PI_REM) + 28'(ROUND_ADD);
            sgn_b1_reg <= sgn_a_reg;
            car_b1_reg <= car_a_reg;

            mq_b2_reg  <= mq_b1_reg;
            dq_b2_reg  <= 39'(mr_b1_reg[27:9]) * 39'(DIV45_MUL);
            sgn_b2_reg <= sgn_b1_reg;
            car_b2_reg <= car_b1_reg;

            theta_b3_reg <= sgn_b2_reg ? -$signed(theta_mag) : $signed(theta_mag);
            car_b3_reg   <= car_b2_reg;
        end
    end

    // ---------------- cordic
    logic                       vc;
    logic signed [CORDIC_W-1:0] cos_raw;
    logic signed [CORDIC_W-1:0] sin_raw;
    logic [CARRY_W-1:0]         car_c;

    aarm_cordic #(
        .TRIG_STAGES (TRIG_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vb3_reg),
        .theta     (theta_b3_reg),
        .carry_in  (car_b3_reg),
        .out_valid (vc),
        .cos_q30   (cos_raw),
        .sin_q30   (sin_raw),
        .carry_out (car_c)
    );

    logic               c_neg;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [CORDIC_W-1:0] cs;
    logic signed [CORDIC_W-1:0] sn;

    assign c_neg = car_c[48];
    assign ax    = $signed(car_c[47:32]);
    assign ay    = $signed(car_c[31:16]);
    assign az    = $signed(car_c[15:0]);
    assign cs    = c_neg ? -cos_raw : cos_raw;
    assign sn    = c_neg ? -sin_raw : sin_raw;

    // ---------------- stage e1: axis products, sine terms, t = 1 - c
    // pq order: xx, yy, zz, xy, xz, yz; su order: s*x, s*y, s*z
    logic                       ve1_reg;
    logic signed [CORDIC_W-1:0] c_e1_reg;
    logic signed [CORDIC_W-1:0] t_e1_reg;
    logic signed [PQ_W-1:0]     pq_e1_reg [6];
    logic signed [SU_W-1:0]     su_e1_reg [3];

    // ---------------- stage e2: t * p * q, scaled down by FRAC_BITS
    logic                       ve2_reg;
    logic signed [CORDIC_W-1:0] c_e2_reg;
    logic signed [TPQ_W-1:0]    tpq_e2_reg [6];
    logic signed [SU_W-1:0]     su_e2_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve1_reg       <= 1'b0;
            ve2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ve1_reg       <= vc;
            ve2_reg       <= ve1_reg;
            out_valid_reg <= ve2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_e1_reg     <= cs;
            t_e1_reg     <= ONE_Q30 - cs;
            pq_e1_reg[0] <= PQ_W'(ax) * PQ_W'(ax);
            pq_e1_reg[1] <= PQ_W'(ay) * PQ_W'(ay);
            pq_e1_reg[2] <= PQ_W'(az) * PQ_W'(az);
            pq_e1_reg[3] <= PQ_W'(ax) * PQ_W'(ay);
            pq_e1_reg[4] <= PQ_W'(ax) * PQ_W'(az);
            pq_e1_reg[5] <= PQ_W'(ay) * PQ_W'(az);
            su_e1_reg[0] <= SU_W'(sn) * SU_W'(ax);
            su_e1_reg[1] <= SU_W'(sn) * SU_W'(ay);
            su_e1_reg[2] <= SU_W'(sn) * SU_W'(az);

            c_e2_reg <= c_e1_reg;
            for (int k = 0; k < 6; k++)
            begin
                tpq_e2_reg[k] <= (TPQ_W'(t_e1_reg) * TPQ_W'(pq_e1_reg[k])) >>> FRAC_BITS;
            end
            for (int k = 0; k < 3; k++)
            begin
                su_e2_reg[k] <= su_e1_reg[k];
            end
        end
    end

    // ---------------- stage e3: sum, round and saturate
    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        rnd = (acc + (ACC_W'(1) <<< 29)) >>> 30;
        if (rnd > ACC_W'(32767))
        begin
            return 16'sh7fff;
        end
        else if (rnd < -ACC_W'(32768))
        begin
            return -16'sh8000;
        end
        return rnd[15:0];
    endfunction

    logic signed [ACC_W-1:0] cdiag;
    logic signed [ACC_W-1:0] tp [6];
    logic signed [ACC_W-1:0] su [3];

    always_comb
    begin
        cdiag = ACC_W'(c_e2_reg) <<< FRAC_BITS;
        for (int k = 0; k < 6; k++)
        begin
            tp[k] = ACC_W'(tpq_e2_reg[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            su[k] = ACC_W'(su_e2_reg[k]);
        end
    end

    logic signed [15:0] r00_reg, r01_reg, r02_reg;
    logic signed [15:0] r10_reg, r11_reg, r12_reg;
    logic signed [15:0] r20_reg, r21_reg, r22_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r00_reg <= round_sat(cdiag + tp[0]);
            r01_reg <= round_sat(tp[3] - su[2]);
            r02_reg <= round_sat(tp[4] + su[1]);
            r10_reg <= round_sat(tp[3] + su[2]);
            r11_reg <= round_sat(cdiag + tp[1]);
            r12_reg <= round_sat(tp[5] - su[0]);
            r20_reg <= round_sat(tp[4] - su[1]);
            r21_reg <= round_sat(tp[5] + su[0]);
            r22_reg <= round_sat(cdiag + tp[2]);
        end
    end

    assign r00 = r00_reg;
    assign r01 = r01_reg;
    assign r02 = r02_reg;
    assign r10 = r10_reg;
    assign r11 = r11_reg;
    assign r12 = r12_reg;
    assign r20 = r20_reg;
    assign r21 = r21_reg;
    assign r22 = r22_reg;

endmodule

FILE: dv/axis_angle_rotation_matrix_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top_tb
// Streams angle/axis requests through the rotation matrix block, predicts each
// 3x3 matrix with a bit-exact fixed-point Rodrigues and cordic model, and
// compares every entry of every result in order.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top_tb;

    import aarm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [16:0] ang;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } rot_req_t;

    typedef logic signed [15:0] matrix_t [9];

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [16:0] angle_deg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

    rot_req_t pending_reqs [$];
    logic signed [15:0] expected_entries [$];
    int  mismatch_count;
    int  results_seen;
    int  accepted_reqs;
    bit  stim_done;
    bit  hold_off;
    bit  no_idle;
    int  quiet_cycles;

    axis_angle_rotation_matrix_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .angle_deg(angle_deg), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
        .r20(r20), .r21(r21), .r22(r22)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int sh);
        return v >>> sh;
    endfunction

    // cosine and sine in Q30 from the angle, after folding it into [-90, 90] degrees
    function automatic void cordic_trig(input longint ang, output longint cs,
                                        output longint sn);
        longint r, mag, theta, x, y, z, nx;
        bit neg;
        r = ang % 46080;
        neg = 1'b0;
        if (r < 0) r += 46080;
        if (r >= 23040) r -= 46080;
        if (r > 11520)
        begin
            r -= 23040;
            neg = 1'b1;
        end
        else if (r < -11520)
        begin
            r += 23040;
            neg = 1'b1;
        end
        mag = (r < 0) ? -r : r;
        theta = (mag * 64'sd3373259426 + 11520) / 23040;
        if (r < 0) theta = -theta;
        x = 652032874;
        y = 0;
        z = theta;
        for (int i = 0; i < TRIG_STAGES_DEF; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= longint'(ATAN_Q30[i % 32]);
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += longint'(ATAN_Q30[i % 32]);
            end
            x = nx;
        end
        cs = neg ? -x : x;
        sn = neg ? -y : y;
    endfunction

    function automatic logic signed [15:0] matrix_entry(longint c, longint t, longint s,
        bit diag, longint p, longint q, longint u, int sgn);
        longint acc;
        acc = floor_shift(t * (p * q), FRAC_BITS_DEF);
        if (diag) acc += c * (longint'(1) <<< FRAC_BITS_DEF);
        if (sgn > 0) acc += s * u;
        else if (sgn < 0) acc -= s * u;
        acc = floor_shift(acc + (longint'(1) <<< 29), 30);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[15:0];
    endfunction

    task automatic predict_rotation(input rot_req_t rq);
        longint c, s, t, x, y, z;
        cordic_trig(rq.ang, c, s);
        t = (longint'(1) <<< 30) - c;
        x = rq.ax;
        y = rq.ay;
        z = rq.az;
        expected_entries.push_back(matrix_entry(c, t, s, 1, x, x, 0, 0));
        expected_entries.push_back(matrix_entry(c, t, s, 0, x, y, z, -1));
        expected_entries.push_back(matrix_entry(c, t, s, 0, x, z, y, 1));
        expected_entries.push_back(matrix_entry(c, t, s, 0, x, y, z, 1));
        expected_entries.push_back(matrix_entry(c, t, s, 1, y, y, 0, 0));
        expected_entries.push_back(matrix_entry(c, t, s, 0, y, z, x, -1));
        expected_entries.push_back(matrix_entry(c, t, s, 0, x, z, y, -1));
        expected_entries.push_back(matrix_entry(c, t, s, 0, y, z, x, 1));
        expected_entries.push_back(matrix_entry(c, t, s, 1, z, z, 0, 0));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatch_count++;
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic add_req(input int a, input int x, input int y, input int z);
        rot_req_t rq;
        rq.ang = 17'(a);
        rq.ax = 16'(x);
        rq.ay = 16'(y);
        rq.az = 16'(z);
        pending_reqs.push_back(rq);
    endtask

    initial
    begin
        rot_req_t rq;
        int n;
        rst_n = 1'b0;
        stim_done = 1'b0;
        // directed: angle extremes, quadrant edges, axis extremes
        add_req(0, 16384, 0, 0);
        add_req(11520, 0, 16384, 0);
        add_req(-11520, 0, 0, 16384);
        add_req(11521, 16384, 16384, 16384);
        add_req(-11521, -16384, 0, 0);
        add_req(23040, 0, -16384, 0);
        add_req(-23040, 0, 0, -16384);
        add_req(23039, 9459, 9459, 9459);
        add_req(46080, 16384, 0, 0);
        add_req(-46080, 0, 16384, 0);
        add_req(65535, 16384, -16384, 16384);
        add_req(-65536, -32768, -32768, -32768);
        add_req(34560, 32767, 32767, 32767);
        add_req(-34560, -32768, 32767, -1);
        add_req(5760, 11585, 11585, 0);
        add_req(1, 0, 0, 0);
        add_req(-1, 1, -1, 1);
        add_req(17280, -32768, 0, 32767);
        n = 0;
        while (n < 1950)
        begin
            case ($urandom_range(0, 9))
                0: rq.ang = 17'($urandom);
                1: rq.ang = 17'($urandom_range(0, 8) * 5760 - 23040);
                default: rq.ang = 17'($signed($urandom_range(0, 92160)) - 46080);
            endcase
            rq.ax = rand_axis();
            rq.ay = rand_axis();
            rq.az = rand_axis();
            pending_reqs.push_back(rq);
            n++;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            angle_deg <= '0;
            axis_x    <= '0;
            axis_y    <= '0;
            axis_z    <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                predict_rotation({angle_deg, axis_x, axis_y, axis_z});
                accepted_reqs++;
            end
            if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 20))
            begin
                rot_req_t rq;
                rq = pending_reqs.pop_front();
                in_valid  <= 1'b1;
                angle_deg <= rq.ang;
                axis_x    <= rq.ax;
                axis_y    <= rq.ay;
                axis_z    <= rq.az;
            end
            else
            begin
                in_valid <= 1'b0;
                if (pending_reqs.size() == 0) stim_done <= 1'b1;
            end
        end
    end

    // receiver pressure and idle-free stretch, timed in its own process
    initial
    begin
        hold_off = 1'b0;
        no_idle  = 1'b0;
        wait (accepted_reqs > 300);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
        wait (accepted_reqs > 800);
        @(posedge clk);
        no_idle = 1'b1;
        wait (accepted_reqs > 1100);
        @(posedge clk);
        no_idle = 1'b0;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                matrix_t got;
                got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
                if (expected_entries.size() == 0)
                begin
                    report_mismatch("unexpected result", 0, 0);
                end
                else
                begin
                    for (int k = 0; k < 9; k++)
                    begin
                        logic signed [15:0] want;
                        want = expected_entries.pop_front();
                        if (got[k] !== want)
                            report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), got[k], want);
                    end
                end
                results_seen++;
            end
            out_ready <= !hold_off && (no_idle || $urandom_range(0, 99) >= 20);
        end
    end

    // watchdog and end of run
    initial
    begin
        mismatch_count = 0;
        results_seen = 0;
        accepted_reqs = 0;
        quiet_cycles = 0;
        wait (rst_n);
        while (!(stim_done && !in_valid && expected_entries.size() == 0))
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d matrices outstanding",
                         expected_entries.size() / 9);
                $display("Regression FAIL");
                $finish;
            end
        end
        repeat (TRIG_STAGES_DEF + 20) @(posedge clk);
        if (out_valid)
            report_mismatch("result after last expected", 0, 0);
        $display("covered %0d rotation requests, %0d matrices checked", accepted_reqs,
                 results_seen);
        $display("angles across several turns, axis extremes, receiver stall and gaps");
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic.sv
rtl/core/axis_angle_rotation_matrix_top.sv
dv/axis_angle_rotation_matrix_top_tb.sv
